FILE: hdl/ghp_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle pool package
// Shared payload types, operation and status codes, and field widths.
// ----------------------------------------------------------------------------
package ghp_pkg;

   localparam int DEFAULT_NUM_SLOTS = 4;
   localparam int HANDLE_W          = 32;
   localparam int LOW_W             = 16;
   localparam int SEQ_W             = 15;

   typedef enum logic [1:0] {
      KIND_CREATE   = 2'd0,
      KIND_DESTROY  = 2'd1,
      KIND_VALIDATE = 2'd2,
      KIND_CHECK    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_UNUSED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] new_handle;
      logic [1:0]          status;
      logic [1:0]          slot;
   } rsp_type;

   typedef struct packed {
      logic             in_use;
      logic [SEQ_W-1:0] seq;
   } slot_entry_type;

endpackage

FILE: hdl/ghp_ram.sv
// ----------------------------------------------------------------------------
// Generational handle pool RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module ghp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/generational_handle_pool_core.sv
// ----------------------------------------------------------------------------
// Generational handle pool core
// Allocates, releases and checks 32-bit generational handles for a pool of
// NUM_SLOTS slots.
// ----------------------------------------------------------------------------
// After reset the block sweeps both RAMs, one slot per cycle, so it takes no
// request until the sweep is done. It then works on one request at a time:
// destroy, validate and check pass from accept with the slot RAM read to the
// response and, for destroy, the write-back; a successful create first reads
// the free stack RAM, as that slot must be known before the slot RAM is read.
// A finished response waits in an output register, so the next request is
// taken while the previous response is still stalled.
module generational_handle_pool_core #(
   parameter int NUM_SLOTS = ghp_pkg::DEFAULT_NUM_SLOTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ghp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ghp_pkg::rsp_type rsp_payload
);

   import ghp_pkg::*;

   localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_STACK  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]   free_count_ff, free_count_in;
   req_type            req_ff, req_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               slot_wr_en, slot_rd_en;
   logic [SLOT_W-1:0]  slot_wr_addr, slot_rd_addr;
   slot_entry_type     slot_wr_data;
   logic [ENTRY_W-1:0] slot_rd_raw;
   slot_entry_type     slot_rd;

   logic               stack_wr_en, stack_rd_en;
   logic [SLOT_W-1:0]  stack_wr_addr, stack_rd_addr;
   logic [SLOT_W-1:0]  stack_wr_data;
   logic [SLOT_W-1:0]  stack_rd_data;

   logic               accept;
   logic               finish;
   logic [LOW_W-1:0]   in_low;
   logic [LOW_W-1:0]   cur_low;
   logic               cur_in_range;
   logic               cur_seq_ok;
   logic               cur_valid;
   logic [SEQ_W-1:0]   seq_next;
   logic [SLOT_W+1:0]  slot_ext;

   assign slot_rd  = slot_entry_type'(slot_rd_raw);
   assign accept   = req_valid && !req_stall;
   assign finish   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign in_low   = req_payload.handle[LOW_W-1:0];
   assign cur_low  = req_ff.handle[LOW_W-1:0];

   // A handle names a slot when its low half is slot+1 for an existing slot.
   assign cur_in_range = (cur_low != '0) && (cur_low <= LOW_W'(NUM_SLOTS));
   // Bit 31 is never set in a stored sequence, so such a handle never matches.
   assign cur_seq_ok   = !req_ff.handle[HANDLE_W-1] &&
                         (req_ff.handle[HANDLE_W-2:LOW_W] == slot_rd.seq);
   assign cur_valid    = cur_in_range && cur_seq_ok;
   assign seq_next     = (slot_rd.seq == {SEQ_W{1'b1}}) ? SEQ_W'(1)
                                                        : slot_rd.seq + SEQ_W'(1);
   assign slot_ext     = {2'b00, slot_ff};

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      free_count_in = free_count_ff;
      req_in        = req_ff;
      slot_in       = slot_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      slot_wr_en    = 1'b0;
      slot_wr_addr  = slot_ff;
      slot_wr_data  = '0;
      slot_rd_en    = 1'b0;
      slot_rd_addr  = slot_ff;
      stack_wr_en   = 1'b0;
      stack_wr_addr = free_count_ff[SLOT_W-1:0];
      stack_wr_data = slot_ff;
      stack_rd_en   = 1'b0;
      stack_rd_addr = SLOT_W'(free_count_ff - CNT_W'(1));

      unique case (state_ff)
         ST_CLEAR: begin
            // The stack is filled so that slot 0 ends up on top.
            slot_wr_en    = 1'b1;
            slot_wr_addr  = clr_idx_ff;
            slot_wr_data  = '0;
            stack_wr_en   = 1'b1;
            stack_wr_addr = clr_idx_ff;
            stack_wr_data = SLOT_W'(NUM_SLOTS - 1) - clr_idx_ff;
            clr_idx_in    = clr_idx_ff + SLOT_W'(1);
            if (clr_idx_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_payload;
               if (req_payload.kind == KIND_CREATE) begin
                  if (free_count_ff != '0) begin
                     stack_rd_en = 1'b1;
                     state_in    = ST_STACK;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  slot_in      = SLOT_W'(in_low - LOW_W'(1));
                  slot_rd_en   = 1'b1;
                  slot_rd_addr = SLOT_W'(in_low - LOW_W'(1));
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_STACK: begin
            slot_in      = stack_rd_data;
            slot_rd_en   = 1'b1;
            slot_rd_addr = stack_rd_data;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish) begin
               rsp_valid_in      = 1'b1;
               rsp_in.new_handle = '0;
               rsp_in.status     = STATUS_OK;
               rsp_in.slot       = slot_ext[1:0];
               state_in          = ST_IDLE;
               priority if (req_ff.kind == KIND_CREATE) begin
                  if (free_count_ff == '0) begin
                     rsp_in.status = STATUS_FULL;
                     rsp_in.slot   = 2'b00;
                  end else begin
                     rsp_in.new_handle = {1'b0, slot_rd.seq,
                                          LOW_W'(slot_ff) + LOW_W'(1)};
                     slot_wr_en          = 1'b1;
                     slot_wr_data.in_use = 1'b1;
                     slot_wr_data.seq    = slot_rd.seq;
                     free_count_in       = free_count_ff - CNT_W'(1);
                  end
               end else if (req_ff.kind == KIND_DESTROY) begin
                  if (!cur_valid) begin
                     rsp_in.status = STATUS_INVALID;
                     rsp_in.slot   = 2'b00;
                  end else begin
                     slot_wr_en          = 1'b1;
                     slot_wr_data.in_use = 1'b0;
                     slot_wr_data.seq    = seq_next;
                     // Only a slot that is in use goes back on the free stack.
                     if (slot_rd.in_use && (free_count_ff < CNT_W'(NUM_SLOTS))) begin
                        stack_wr_en   = 1'b1;
                        stack_wr_addr = free_count_ff[SLOT_W-1:0];
                        stack_wr_data = slot_ff;
                        free_count_in = free_count_ff + CNT_W'(1);
                     end
                  end
               end else begin
                  if (!cur_valid) begin
                     rsp_in.status = STATUS_INVALID;
                     rsp_in.slot   = 2'b00;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         free_count_ff <= CNT_W'(NUM_SLOTS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   ghp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS),
      .ADDR_W(SLOT_W)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_wr_en),
      .wr_addr(slot_wr_addr),
      .wr_data(ENTRY_W'(slot_wr_data)),
      .rd_en  (slot_rd_en),
      .rd_addr(slot_rd_addr),
      .rd_data(slot_rd_raw)
   );

   ghp_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_SLOTS),
      .ADDR_W(SLOT_W)
   ) u_stack_ram (
      .clock  (clock),
      .wr_en  (stack_wr_en),
      .wr_addr(stack_wr_addr),
      .wr_data(stack_wr_data),
      .rd_en  (stack_rd_en),
      .rd_addr(stack_rd_addr),
      .rd_data(stack_rd_data)
   );

endmodule
